>>> hw/rtl/fpptr_pkg.sv
// Shared types and constants of the four-port pad tap reader.
// Used by fpptr_frame, fpptr_ports and four_port_pad_tap_reader_core.
package fpptr_pkg;

	localparam int FRAME_NIBBLES_DEF = 18;
	localparam int PORT_COUNT_DEF    = 4;

	localparam int S_TDATA_W  = 16;
	localparam int M_TDATA_W  = 40;
	localparam int IDX_W      = 5;
	localparam int SLOT_IDX_W = 4;
	localparam int SETTLE_W   = 16;

	localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd1600;

	localparam logic [3:0] NIB_HEADER = 4'hF;
	localparam logic [3:0] ID_THREE   = 4'hE;
	localparam logic [3:0] ID_TWO     = 4'hF;

	localparam logic [7:0] AXIS_LOW  = 8'd0;
	localparam logic [7:0] AXIS_MID  = 8'd128;
	localparam logic [7:0] AXIS_HIGH = 8'd255;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SETTLE,
		PH_HANDSHAKE,
		PH_POST
	} phase_t;

	// staging write from the frame reader into the port store
	typedef struct packed {
		logic                  clear;
		logic                  we;
		logic [SLOT_IDX_W-1:0] slot;
		logic [3:0]            nib;
		logic                  commit;
	} wr_t;

	typedef struct packed {
		logic select_out;
		logic request_out;
		logic busy_res;
		logic frame_ok;
		logic frame_bad;
	} frm_res_t;

	typedef struct packed {
		logic       port_changed;
		logic       report_valid;
		logic [2:0] rpt_port;
		logic [7:0] axis_x;
		logic [7:0] axis_y;
		logic [7:0] buttons;
	} rpt_t;

endpackage

>>> hw/rtl/fpptr_frame.sv
// Frame reader: pin handshake sequencer, header and port ID capture, slot steering.
// Depends on fpptr_pkg.
module fpptr_frame #(
	parameter int FRAME_NIBBLES = fpptr_pkg::FRAME_NIBBLES_DEF,
	parameter int PORT_COUNT    = fpptr_pkg::PORT_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              acc,
	input  logic [fpptr_pkg::SETTLE_W-1:0]    settle,
	input  logic                              ack_level,
	input  logic [3:0]                        data_nibble,
	input  logic                              start_poll,
	output fpptr_pkg::wr_t                    wr,
	output fpptr_pkg::frm_res_t               res
);
	import fpptr_pkg::*;

	localparam int DATA_START = 2 + PORT_COUNT;

	phase_t               phase_q, phase_d;
	logic [IDX_W-1:0]     idx_q, idx_d, idx_n, off;
	logic [SETTLE_W-1:0]  wait_q, wait_d;
	logic                 req_q, req_d;
	logic [1:0][3:0]      hdr_q;
	logic [PORT_COUNT-1:0][3:0] id_q;
	logic [PORT_COUNT-1:0][1:0] sz;
	logic [PORT_COUNT:0][3:0]   cum;
	logic                 store;
	logic [3:0]           nib;
	logic [SLOT_IDX_W-1:0] slot;
	logic                 slot_hit;

	assign nib = ~data_nibble;
	assign off = idx_q - IDX_W'(DATA_START);
	assign idx_n = idx_q + 1'b1;

	// map the current data nibble onto a port slot from the captured IDs
	always_comb begin
		cum[0]   = '0;
		slot     = '0;
		slot_hit = 1'b0;
		for (int p = 0; p < PORT_COUNT; p++) begin
			sz[p] = (id_q[p] == ID_THREE) ? 2'd3 : (id_q[p] == ID_TWO) ? 2'd2 : 2'd0;
			cum[p+1] = cum[p] + {2'b00, sz[p]};
		end
		for (int p = 0; p < PORT_COUNT; p++) begin
			if (off >= {1'b0, cum[p]} && off < {1'b0, cum[p+1]}) begin
				slot_hit = 1'b1;
				slot = SLOT_IDX_W'(p * 3) + SLOT_IDX_W'(off - {1'b0, cum[p]});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			idx_q   <= '0;
			wait_q  <= '0;
			req_q   <= 1'b1;
		end else if (acc) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			wait_q  <= wait_d;
			req_q   <= req_d;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && store) begin
			for (int i = 0; i < 2; i++)
				if (idx_q == IDX_W'(i)) hdr_q[i] <= nib;
			for (int p = 0; p < PORT_COUNT; p++)
				if (idx_q == IDX_W'(2 + p)) id_q[p] <= nib;
		end
	end

	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		wait_d  = wait_q;
		req_d   = req_q;
		store   = 1'b0;
		wr      = '0;
		res     = '0;
		unique case (phase_q)
			PH_IDLE: begin
				if (start_poll) begin
					phase_d  = PH_SETTLE;
					idx_d    = '0;
					wait_d   = settle;
					wr.clear = 1'b1;
				end
			end
			PH_SETTLE: begin
				if (wait_q == '0) begin
					idx_d   = '0;
					phase_d = PH_HANDSHAKE;
					req_d   = 1'b0;
				end else begin
					wait_d = wait_q - 1'b1;
				end
			end
			PH_HANDSHAKE: begin
				if (ack_level == idx_q[0]) begin
					store   = 1'b1;
					phase_d = PH_POST;
					wait_d  = settle;
					if (idx_q >= IDX_W'(DATA_START) && slot_hit) begin
						wr.we   = 1'b1;
						wr.slot = slot;
						wr.nib  = nib;
					end
				end
			end
			PH_POST: begin
				if (wait_q == '0) begin
					if (idx_n >= IDX_W'(FRAME_NIBBLES)) begin
						req_d   = 1'b1;
						phase_d = PH_IDLE;
						idx_d   = '0;
						if (hdr_q[0] == NIB_HEADER && hdr_q[1] == NIB_HEADER) begin
							res.frame_ok = 1'b1;
							wr.commit    = 1'b1;
						end else begin
							res.frame_bad = 1'b1;
						end
					end else begin
						idx_d   = idx_n;
						phase_d = PH_HANDSHAKE;
						req_d   = idx_n[0];
					end
				end else begin
					wait_d = wait_q - 1'b1;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
		res.select_out  = (phase_d == PH_IDLE);
		res.busy_res    = (phase_d != PH_IDLE);
		res.request_out = req_d;
	end

	ap_idle_req_high: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> req_q)
		else $error("request line low while idle");
	ap_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q < IDX_W'(FRAME_NIBBLES))
		else $error("nibble index past frame end");
	ap_commit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc && wr.commit |=> phase_q == PH_IDLE)
		else $error("commit without return to idle");

endmodule

>>> hw/rtl/fpptr_ports.sv
// Port store: staging, committed and reported pad data, change query and report builder.
// Depends on fpptr_pkg.
module fpptr_ports #(
	parameter int PORT_COUNT = fpptr_pkg::PORT_COUNT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           acc,
	input  fpptr_pkg::wr_t wr,
	input  logic [2:0]     query_port,
	input  logic [2:0]     report_port,
	output fpptr_pkg::rpt_t rpt
);
	import fpptr_pkg::*;

	localparam int SLOTS = 3 * PORT_COUNT;

	logic [SLOTS-1:0][3:0] pd_q, rep_q, stage_q;
	logic [SLOTS-1:0]      mask_q;
	logic                  first_q;
	logic                  q_ok, r_ok;
	logic [11:0]           q_pd, q_rep, r_pd;
	logic [3:0]            n0, n1, n2;

	assign q_ok = (query_port != 3'd0) && (query_port <= 3'(PORT_COUNT));
	assign r_ok = (report_port != 3'd0) && (report_port <= 3'(PORT_COUNT));

	always_comb begin
		q_pd  = '0;
		q_rep = '0;
		r_pd  = '0;
		for (int p = 0; p < PORT_COUNT; p++) begin
			if (query_port == 3'(p + 1)) begin
				q_pd  = {pd_q[p*3+2], pd_q[p*3+1], pd_q[p*3]};
				q_rep = {rep_q[p*3+2], rep_q[p*3+1], rep_q[p*3]};
			end
			if (report_port == 3'(p + 1))
				r_pd = {pd_q[p*3+2], pd_q[p*3+1], pd_q[p*3]};
		end
	end

	assign n0 = r_pd[3:0];
	assign n1 = r_pd[7:4];
	assign n2 = r_pd[11:8];

	always_comb begin
		rpt = '0;
		if (q_ok)
			rpt.port_changed = first_q || (q_pd != q_rep);
		if (r_ok) begin
			rpt.report_valid = 1'b1;
			rpt.rpt_port     = report_port;
			rpt.axis_y = n0[1] ? AXIS_HIGH : n0[0] ? AXIS_LOW : AXIS_MID;
			rpt.axis_x = n0[3] ? AXIS_HIGH : n0[2] ? AXIS_LOW : AXIS_MID;
			rpt.buttons = {n2[3], n2[0], n2[1], n2[2], n1[3], n1[1], n1[0], n1[2]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pd_q    <= '0;
			rep_q   <= '0;
			mask_q  <= '0;
			first_q <= 1'b1;
		end else if (acc) begin
			if (q_ok) first_q <= 1'b0;
			for (int p = 0; p < PORT_COUNT; p++)
				if (report_port == 3'(p + 1))
					for (int j = 0; j < 3; j++) rep_q[p*3+j] <= pd_q[p*3+j];
			if (wr.clear) mask_q <= '0;
			for (int k = 0; k < SLOTS; k++) begin
				if (wr.we && wr.slot == SLOT_IDX_W'(k)) mask_q[k] <= 1'b1;
				if (wr.commit && mask_q[k]) pd_q[k] <= stage_q[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && wr.we)
			for (int k = 0; k < SLOTS; k++)
				if (wr.slot == SLOT_IDX_W'(k)) stage_q[k] <= wr.nib;
	end

	ap_first_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && q_ok |=> !first_q)
		else $error("first query flag not cleared");
	ap_report_commits: assert property (@(posedge clk) disable iff (!arst_n)
		acc && r_ok && !wr.commit |=> !rpt.port_changed || !q_ok || first_q
			|| query_port != $past(report_port))
		else $error("report did not commit port data");
	ap_clear_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr.clear && wr.commit))
		else $error("staging clear and commit together");

endmodule

>>> hw/rtl/four_port_pad_tap_reader_core.sv
// Top level of the four-port pad tap reader: stream ports, settle register, result register.
// Depends on fpptr_pkg, fpptr_frame and fpptr_ports.
//
// Use: every request on the slave stream is one tick of the pad bus: the sampled
// TL pin, the four data pins and optional host requests (start a frame, ask for a
// port's change flag, build a port's report). Every request gives exactly one result
// on the master stream: the TH and TR drives, busy, frame pulses, the change flag and
// the report fields. The block drives TH low, waits settle ticks, then walks the
// nibbles of a frame by toggling TR and waiting for TL to follow; a frame with a bad
// header is dropped, a good one is unpacked into the per-port store.
// Each result is held in the single result register after the frame sequencer and port
// store; one request is taken every cycle while the receiver is not stalling.
// A request is taken whenever the result register is empty or being drained, so
// a stalled receiver holds the result and, one request later, stalls the sender.
// The settle count comes in on the cfg channel, always ready; write it only while
// idle. Reset (arst_n low) empties the result register, returns the sequencer to
// idle with TR high, clears the port store and re-arms the first-query flag.
module four_port_pad_tap_reader_core #(
	parameter int FRAME_NIBBLES = fpptr_pkg::FRAME_NIBBLES_DEF,
	parameter int PORT_COUNT    = fpptr_pkg::PORT_COUNT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// ack_level[0], data_nibble[4:1], start_poll[5], query_port[8:6],
	// report_port[11:9], zero fill [15:12]
	input  logic [fpptr_pkg::S_TDATA_W-1:0]    s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// select_out[0], request_out[1], busy_res[2], frame_ok[3], frame_bad[4],
	// port_changed[5], report_valid[6], rpt_port[9:7], axis_x[17:10],
	// axis_y[25:18], buttons[33:26], zero fill [39:34]
	output logic [fpptr_pkg::M_TDATA_W-1:0]    m_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fpptr_pkg::SETTLE_W-1:0]     cfg_data
);
	import fpptr_pkg::*;

	localparam int RES_W = $bits(rpt_t) + $bits(frm_res_t);

	logic                 acc;
	logic [SETTLE_W-1:0]  settle_q;
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	wr_t                  wr;
	frm_res_t             frm;
	rpt_t                 rpt;
	logic                 ok_out, bad_out, busy_out, sel_out;

	// take a request whenever the result register can move on
	assign s_tready  = !m_tvalid_q || m_tready;
	assign acc       = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_RESET;
		end else if (cfg_valid) begin
			settle_q <= cfg_data;
		end
	end

	fpptr_frame #(
		.FRAME_NIBBLES(FRAME_NIBBLES),
		.PORT_COUNT   (PORT_COUNT)
	) u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.settle     (settle_q),
		.ack_level  (s_tdata[0]),
		.data_nibble(s_tdata[4:1]),
		.start_poll (s_tdata[5]),
		.wr         (wr),
		.res        (frm)
	);

	fpptr_ports #(
		.PORT_COUNT(PORT_COUNT)
	) u_ports (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.wr         (wr),
		.query_port (s_tdata[8:6]),
		.report_port(s_tdata[11:9]),
		.rpt        (rpt)
	);

	// hold the result until taken; load a new one on every request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (acc) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			m_tdata_q <= {(M_TDATA_W - RES_W)'(0),
				rpt.buttons, rpt.axis_y, rpt.axis_x, rpt.rpt_port,
				rpt.report_valid, rpt.port_changed,
				frm.frame_bad, frm.frame_ok, frm.busy_res, frm.request_out,
				frm.select_out};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign sel_out  = m_tdata_q[0];
	assign busy_out = m_tdata_q[2];
	assign ok_out   = m_tdata_q[3];
	assign bad_out  = m_tdata_q[4];

	ap_ok_bad_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> !(ok_out && bad_out))
		else $error("frame_ok and frame_bad together");
	ap_busy_sel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> busy_out != sel_out)
		else $error("busy and select disagree");
	ap_ok_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && (ok_out || bad_out) |-> !busy_out)
		else $error("frame end while still busy");
	ap_req_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> m_tvalid_q)
		else $error("request lost its result");

endmodule

>>> tb/sv/four_port_pad_tap_reader_core_test.sv
// Self-checking bench for four_port_pad_tap_reader_core: emulates a pad tap on the pins,
// predicts each result from its own copy of the frame reader and port store.
// Depends on fpptr_pkg and the core RTL only.
module four_port_pad_tap_reader_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import fpptr_pkg::*;

	localparam int NIBS      = FRAME_NIBBLES_DEF;
	localparam int PORTS     = PORT_COUNT_DEF;
	localparam int WD_LIMIT  = 1000;
	localparam int MAX_SHOWN = 10;

	// one pin tick, laid out exactly as s_tdata (lowest field last)
	typedef struct packed {
		logic [3:0] fill;
		logic [2:0] report_port;
		logic [2:0] query_port;
		logic       start_poll;
		logic [3:0] data_nibble;
		logic       ack_level;
	} pin_tick_t;

	// one result, laid out exactly as m_tdata
	typedef struct packed {
		logic [5:0] fill;
		logic [7:0] buttons;
		logic [7:0] axis_y;
		logic [7:0] axis_x;
		logic [2:0] rpt_port;
		logic       report_valid;
		logic       port_changed;
		logic       frame_bad;
		logic       frame_ok;
		logic       busy_res;
		logic       request_out;
		logic       select_out;
	} pad_result_t;

	// Tracks the tap reader state, works out the result of every accepted
	// request and holds it until the block delivers the matching result.
	class tap_tick_scoreboard;
		logic [SETTLE_W-1:0] settle = SETTLE_RESET;
		phase_t              phase = PH_IDLE;
		logic [IDX_W-1:0]    nib_idx = '0;
		logic [SETTLE_W-1:0] wait_cnt = '0;
		logic [3:0]          frame_nibs [NIBS];
		logic [3:0]          port_nibs [PORTS*3];
		logic [3:0]          shown_nibs [PORTS*3];
		logic                first_query = 1'b1;
		logic                tr_line = 1'b1;
		pad_result_t         pending_results [$];
		int                  mismatches = 0;

		function new();
			foreach (frame_nibs[i]) frame_nibs[i] = '0;
			foreach (port_nibs[i]) begin
				port_nibs[i] = '0;
				shown_nibs[i] = '0;
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void note_tick(pin_tick_t t);
			pad_result_t r;
			int b, p, j, pos, sz;
			logic [3:0] id;
			r = '0;
			// query sees the reported copy before any report on this tick commits
			if (t.query_port >= 1 && t.query_port <= PORTS) begin
				b = (t.query_port - 1) * 3;
				if (first_query) begin
					first_query = 1'b0;
					r.port_changed = 1'b1;
				end else begin
					r.port_changed = (port_nibs[b] != shown_nibs[b]) ||
						(port_nibs[b+1] != shown_nibs[b+1]) ||
						(port_nibs[b+2] != shown_nibs[b+2]);
				end
			end
			if (t.report_port >= 1 && t.report_port <= PORTS) begin
				b = (t.report_port - 1) * 3;
				for (j = 0; j < 3; j++) shown_nibs[b+j] = port_nibs[b+j];
				r.report_valid = 1'b1;
				r.rpt_port     = t.report_port;
				r.axis_y = port_nibs[b][1] ? AXIS_HIGH : port_nibs[b][0] ? AXIS_LOW : AXIS_MID;
				r.axis_x = port_nibs[b][3] ? AXIS_HIGH : port_nibs[b][2] ? AXIS_LOW : AXIS_MID;
				r.buttons[1] = port_nibs[b+1][0];
				r.buttons[2] = port_nibs[b+1][1];
				r.buttons[0] = port_nibs[b+1][2];
				r.buttons[3] = port_nibs[b+1][3];
				r.buttons[6] = port_nibs[b+2][0];
				r.buttons[5] = port_nibs[b+2][1];
				r.buttons[4] = port_nibs[b+2][2];
				r.buttons[7] = port_nibs[b+2][3];
			end
			case (phase)
				PH_IDLE: begin
					if (t.start_poll) begin
						phase    = PH_SETTLE;
						nib_idx  = '0;
						wait_cnt = settle;
					end
				end
				PH_SETTLE: begin
					if (wait_cnt == 0) begin
						nib_idx = '0;
						phase   = PH_HANDSHAKE;
						tr_line = 1'b0;
					end else begin
						wait_cnt--;
					end
				end
				PH_HANDSHAKE: begin
					if (t.ack_level == nib_idx[0]) begin
						frame_nibs[nib_idx] = ~t.data_nibble;
						phase    = PH_POST;
						wait_cnt = settle;
					end
				end
				default: begin
					if (wait_cnt != 0) begin
						wait_cnt--;
					end else if (nib_idx + 1 < NIBS) begin
						nib_idx = nib_idx + 1'b1;
						phase   = PH_HANDSHAKE;
						tr_line = nib_idx[0];
					end else begin
						nib_idx = '0;
						phase   = PH_IDLE;
						tr_line = 1'b1;
						if (frame_nibs[0] != NIB_HEADER || frame_nibs[1] != NIB_HEADER) begin
							r.frame_bad = 1'b1;
						end else begin
							pos = 2 + PORTS;
							for (p = 0; p < PORTS; p++) begin
								id = frame_nibs[2+p];
								sz = (id == ID_THREE) ? 3 : (id == ID_TWO) ? 2 : 0;
								for (j = 0; j < sz; j++) begin
									if (pos < NIBS) port_nibs[p*3+j] = frame_nibs[pos];
									pos++;
								end
							end
							r.frame_ok = 1'b1;
						end
					end
				end
			endcase
			r.select_out  = (phase == PH_IDLE);
			r.request_out = tr_line;
			r.busy_res    = (phase != PH_IDLE);
			pending_results.push_back(r);
		endfunction

		function void compare(string name, logic [7:0] want, logic [7:0] seen);
			if (want !== seen) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, seen);
			end
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] raw);
			pad_result_t got, want;
			got = pad_result_t'(raw);
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("%0t: result %h arrived with none outstanding", $realtime, raw);
				return;
			end
			want = pending_results.pop_front();
			compare("select_out", 8'(want.select_out), 8'(got.select_out));
			compare("request_out", 8'(want.request_out), 8'(got.request_out));
			compare("busy_res", 8'(want.busy_res), 8'(got.busy_res));
			compare("frame_ok", 8'(want.frame_ok), 8'(got.frame_ok));
			compare("frame_bad", 8'(want.frame_bad), 8'(got.frame_bad));
			compare("port_changed", 8'(want.port_changed), 8'(got.port_changed));
			compare("report_valid", 8'(want.report_valid), 8'(got.report_valid));
			compare("rpt_port", 8'(want.rpt_port), 8'(got.rpt_port));
			compare("axis_x", want.axis_x, got.axis_x);
			compare("axis_y", want.axis_y, got.axis_y);
			compare("buttons", want.buttons, got.buttons);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [SETTLE_W-1:0]   cfg_data;

	tap_tick_scoreboard sb = new();

	// the frame the emulated tap will answer with, as the block should store it
	logic [3:0] tap_frame [NIBS];
	int         src_idle_pct;
	int         sink_stall_pct;
	int         quiet_cycles;

	four_port_pad_tap_reader_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver side: check every accepted result, redraw the stall for the next
	// cycle and keep a watchdog on cycles where nothing at all is accepted.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WD_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	function automatic pin_tick_t mk(logic ack, logic [3:0] nib, logic start,
			logic [2:0] q, logic [2:0] rp);
		pin_tick_t t;
		t = '0;
		t.ack_level   = ack;
		t.data_nibble = nib;
		t.start_poll  = start;
		t.query_port  = q;
		t.report_port = rp;
		return t;
	endfunction

	// Build the next pin tick from the predicted reader state. While a nibble is
	// awaited the tap mostly answers at once with the right TL level and data;
	// otherwise pins carry noise. Starts while busy are thrown in to be ignored.
	function pin_tick_t next_tick(bit may_start);
		pin_tick_t t;
		int style;
		t = mk(1'($urandom_range(1, 0)), 4'($urandom), 1'b0, 3'd0, 3'd0);
		if ($urandom_range(99) < 40) t.query_port = 3'($urandom_range(7, 1));
		if ($urandom_range(99) < 40) t.report_port = 3'($urandom_range(7, 1));
		case (sb.phase)
			PH_IDLE: begin
				if (may_start && $urandom_range(99) < 35) begin
					t.start_poll = 1'b1;
					style = $urandom_range(9);
					foreach (tap_frame[i])
						tap_frame[i] = (style == 0) ? 4'h0 : (style == 1) ? 4'hF : 4'($urandom);
					// mostly a valid header; a frame with a bad header is dropped by the block
					if ($urandom_range(99) < 85) begin
						tap_frame[0] = NIB_HEADER;
						tap_frame[1] = NIB_HEADER;
					end
					for (int p = 0; p < PORTS; p++) begin
						style = $urandom_range(99);
						tap_frame[2+p] = (style < 40) ? ID_THREE :
							(style < 70) ? ID_TWO : 4'($urandom);
					end
				end
			end
			PH_HANDSHAKE: begin
				if ($urandom_range(99) < 65) begin
					t.ack_level   = sb.nib_idx[0];
					t.data_nibble = ~tap_frame[sb.nib_idx];
				end
			end
			default: t.start_poll = ($urandom_range(99) < 10);
		endcase
		return t;
	endfunction

	// Offer one request, with a random gap first, and log it once accepted.
	task automatic send_tick(input pin_tick_t t);
		if ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		s_tdata  <= t;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_tick(t);
	endtask

	// Hold the sender until every outstanding result has been delivered.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_settle(input logic [SETTLE_W-1:0] ticks);
		cfg_data  <= ticks;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.settle = ticks;
	endtask

	initial begin
		int total, quota;
		int settle_plan [7];
		settle_plan = '{0, 1, 3, 0, 2, 7, 0};
		total          = 0;
		quiet_cycles   = 0;
		src_idle_pct   = 15;
		sink_stall_pct = 47;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		m_tready  <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed ticks at the reset settle count, no frame started: queries and
		// reports outside the port range, the first query always flagging a change,
		// reports of all-zero ports, pin extremes.
		send_tick(mk(1'b0, 4'h0, 1'b0, 3'd0, 3'd0));
		send_tick(mk(1'b1, 4'hF, 1'b0, 3'd5, 3'd0));
		send_tick(mk(1'b0, 4'h0, 1'b0, 3'd0, 3'd7));
		send_tick(mk(1'b1, 4'hF, 1'b0, 3'd2, 3'd3));
		send_tick(mk(1'b0, 4'h0, 1'b0, 3'd2, 3'd0));
		send_tick(mk(1'b1, 4'hF, 1'b0, 3'd1, 3'd1));
		send_tick(mk(1'b0, 4'hF, 1'b0, 3'd3, 3'd4));
		send_tick(mk(1'b1, 4'h0, 1'b0, 3'd4, 3'd2));
		send_tick(mk(1'b0, 4'h0, 1'b0, 3'd6, 3'd5));
		send_tick(mk(1'b1, 4'hF, 1'b0, 3'd7, 3'd6));
		send_tick(mk(1'b0, 4'hA, 1'b0, 3'd0, 3'd0));
		send_tick(mk(1'b1, 4'h5, 1'b0, 3'd0, 3'd0));
		drain_results();

		// largest settle count: write it and run idle ticks only
		write_settle({SETTLE_W{1'b1}});
		send_tick(mk(1'b1, 4'h3, 1'b0, 3'd1, 3'd1));
		send_tick(mk(1'b0, 4'hC, 1'b0, 3'd4, 3'd4));
		send_tick(mk(1'b1, 4'h9, 1'b0, 3'd0, 3'd2));
		drain_results();

		// Random frames, one settle count per phase. Each phase runs out its share,
		// finishes the frame under way, then pauses until all results are in.
		foreach (settle_plan[i]) begin
			write_settle(SETTLE_W'(settle_plan[i]));
			quota = total + 85;
			while (total < quota || sb.phase != PH_IDLE) begin
				send_tick(next_tick(total < quota));
				total++;
				if (total == 200) begin
					src_idle_pct   = 47;
					sink_stall_pct = 15;
				end else if (total == 400) begin
					src_idle_pct   = 0;
					sink_stall_pct = 0;
				end
			end
			drain_results();
		end

		repeat (4) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
